### hdl/sha1_hash_engine_core_assert.svh
// Assertion macros for the SHA-1 hash engine core.
`ifndef SHA1_HASH_ENGINE_CORE_ASSERT_SVH
`define SHA1_HASH_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SHA1_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SHA1_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1_ASSERT(lbl, prop, msg)
`define SHA1_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hdl/sha1_pkg.sv
// Types, constants and round functions shared by the SHA-1 hash engine.
package sha1_pkg;

	typedef struct packed {
		logic [31:0] message_word;
		logic [2:0]  byte_count;
		logic        last_word;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_h0;
		logic [31:0] digest_h1;
		logic [31:0] digest_h2;
		logic [31:0] digest_h3;
		logic [31:0] digest_h4;
	} dgst_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} wv_t;

	localparam logic [31:0] IV0 = 32'h6745_2301;
	localparam logic [31:0] IV1 = 32'hEFCD_AB89;
	localparam logic [31:0] IV2 = 32'h98BA_DCFE;
	localparam logic [31:0] IV3 = 32'h1032_5476;
	localparam logic [31:0] IV4 = 32'hC3D2_E1F0;
	localparam wv_t IV = '{a: IV0, b: IV1, c: IV2, d: IV3, e: IV4};

	localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;
	localparam logic [6:0]  NUM_ROUNDS    = 7'd80;

	function automatic logic [31:0] keep_mask(input logic [1:0] cnt);
		logic [31:0] m;
		case (cnt)
			2'd0:    m = 32'h0000_0000;
			2'd1:    m = 32'hFF00_0000;
			2'd2:    m = 32'hFFFF_0000;
			2'd3:    m = 32'hFFFF_FF00;
			default: m = 32'h0000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] pad_bit(input logic [1:0] cnt);
		logic [31:0] m;
		case (cnt)
			2'd0:    m = 32'h8000_0000;
			2'd1:    m = 32'h0080_0000;
			2'd2:    m = 32'h0000_8000;
			2'd3:    m = 32'h0000_0080;
			default: m = 32'h8000_0000;
		endcase
		return m;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] t);
		logic [31:0] k;
		if (t < 7'd20) begin
			k = 32'h5A82_7999;
		end else if (t < 7'd40) begin
			k = 32'h6ED9_EBA1;
		end else if (t < 7'd60) begin
			k = 32'h8F1B_BCDC;
		end else begin
			k = 32'hCA62_C1D6;
		end
		return k;
	endfunction

endpackage

### hdl/sha1_round.sv
// One SHA-1 round: schedule expansion and working variable update.
module sha1_round import sha1_pkg::*; (
	input  logic [6:0]  t,
	input  wv_t         wv,
	input  logic [31:0] x3,
	input  logic [31:0] x8,
	input  logic [31:0] x14,
	input  logic [31:0] x16,
	output logic [31:0] w,
	output wv_t         wv_next
);

	logic [31:0] mix;
	logic [31:0] tmp;

	always_comb begin
		mix = x3 ^ x8 ^ x14 ^ x16;
		if (t < 7'd16) begin
			w = x16;
		end else begin
			w = {mix[30:0], mix[31]};
		end
		tmp = {wv.a[26:0], wv.a[31:27]} + round_f(t, wv.b, wv.c, wv.d) + wv.e
			+ round_k(t) + w;
		wv_next.a = tmp;
		wv_next.b = wv.a;
		wv_next.c = {wv.b[1:0], wv.b[31:2]};
		wv_next.d = wv.c;
		wv_next.e = wv.d;
	end

endmodule

### hdl/sha1_hash_engine_core.sv
// SHA-1 hash engine top level: word intake, padding, round sequencer, schedule memory.
// A message word is taken only while idle; the stall stays high while a block is
// padded or compressed. A full block runs 80 rounds in alternating phases (two
// reads per cycle from the 16-word schedule memory), an issue step and a chaining
// update step. The last word adds padding words and one or two compressions.
// Reset sets the chaining words to the initial values and clears fill and length.
`include "sha1_hash_engine_core_assert.svh"

module sha1_hash_engine_core import sha1_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  word_valid,
	output logic  word_stall,
	input  msg_t  word_data,
	output logic  digest_valid,
	input  logic  digest_stall,
	output dgst_t digest_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_FINAL
	} state_t;

	typedef enum logic [2:0] {
		PAD_NONE,
		PAD_MARK,
		PAD_ZERO,
		PAD_LEN_LO,
		PAD_DONE
	} pad_t;

	state_t      state_q;
	pad_t        pad_q;
	logic [3:0]  fill_q;
	logic [63:0] bitlen_q;
	logic [6:0]  rnd_q;
	logic        ph_q;
	wv_t         chain_q;
	wv_t         work_q;
	logic [31:0] x3_q;
	logic [31:0] x8_q;
	dgst_t       out_q;
	logic        out_valid_q;

	logic [31:0] sched_mem [16];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;

	logic        accept;
	logic        out_load;
	logic [2:0]  cnt_c;
	logic [31:0] load_word;
	logic [31:0] pad_word;
	logic        we;
	logic [3:0]  waddr;
	logic [31:0] wdata;
	logic [3:0]  ra;
	logic [3:0]  rb;
	logic [6:0]  t;
	logic [31:0] w;
	wv_t         wv_next;
	wv_t         sum;

	assign accept       = word_valid && (state_q == ST_IDLE);
	assign word_stall   = (state_q != ST_IDLE);
	assign digest_valid = out_valid_q;
	assign digest_data  = out_q;
	assign t            = rnd_q - 7'd1;
	assign out_load     = (state_q == ST_FINAL) && (pad_q == PAD_DONE)
		&& (!out_valid_q || !digest_stall);

	assign sum.a = chain_q.a + work_q.a;
	assign sum.b = chain_q.b + work_q.b;
	assign sum.c = chain_q.c + work_q.c;
	assign sum.d = chain_q.d + work_q.d;
	assign sum.e = chain_q.e + work_q.e;

	sha1_round u_round (
		.t       (t),
		.wv      (work_q),
		.x3      (x3_q),
		.x8      (x8_q),
		.x14     (rd_a_q),
		.x16     (rd_b_q),
		.w       (w),
		.wv_next (wv_next)
	);

	always_comb begin
		cnt_c = (word_data.byte_count > 3'd4) ? 3'd4 : word_data.byte_count;
		if (!word_data.last_word || cnt_c == 3'd4) begin
			load_word = word_data.message_word;
		end else begin
			load_word = (word_data.message_word & keep_mask(cnt_c[1:0])) | pad_bit(cnt_c[1:0]);
		end

		case (pad_q)
			PAD_MARK:   pad_word = PAD_MARK_WORD;
			PAD_ZERO:   pad_word = (fill_q == 4'd14) ? bitlen_q[63:32] : 32'd0;
			PAD_LEN_LO: pad_word = bitlen_q[31:0];
			default:    pad_word = 32'd0;
		endcase

		we    = 1'b0;
		waddr = fill_q;
		wdata = load_word;
		case (state_q)
			ST_IDLE: begin
				we = accept;
			end
			ST_PAD: begin
				we    = 1'b1;
				wdata = pad_word;
			end
			ST_ROUND: begin
				we    = !ph_q && (rnd_q != 7'd0) && (t >= 7'd16);
				waddr = t[3:0];
				wdata = w;
			end
			default: begin
				we = 1'b0;
			end
		endcase

		if (!ph_q) begin
			ra = rnd_q[3:0] - 4'd3;
			rb = rnd_q[3:0] - 4'd8;
		end else begin
			ra = rnd_q[3:0] - 4'd14;
			rb = rnd_q[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			sched_mem[waddr] <= wdata;
		end
		rd_a_q <= sched_mem[ra];
		rd_b_q <= sched_mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_q       <= PAD_NONE;
			fill_q      <= 4'd0;
			bitlen_q    <= 64'd0;
			rnd_q       <= 7'd0;
			ph_q        <= 1'b0;
			chain_q     <= IV;
			work_q      <= '0;
			x3_q        <= 32'd0;
			x8_q        <= 32'd0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !digest_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						fill_q <= fill_q + 4'd1;
						if (!word_data.last_word) begin
							bitlen_q <= bitlen_q + 64'd32;
							pad_q    <= PAD_NONE;
						end else begin
							bitlen_q <= bitlen_q + {58'd0, cnt_c, 3'd0};
							pad_q    <= (cnt_c == 3'd4) ? PAD_MARK : PAD_ZERO;
						end
						if (fill_q == 4'd15) begin
							state_q <= ST_ROUND;
							work_q  <= chain_q;
							rnd_q   <= 7'd0;
							ph_q    <= 1'b0;
						end else if (word_data.last_word) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 4'd1;
					case (pad_q)
						PAD_MARK:   pad_q <= PAD_ZERO;
						PAD_ZERO:   pad_q <= (fill_q == 4'd14) ? PAD_LEN_LO : PAD_ZERO;
						PAD_LEN_LO: pad_q <= PAD_DONE;
						default:    pad_q <= pad_q;
					endcase
					if (fill_q == 4'd15) begin
						state_q <= ST_ROUND;
						work_q  <= chain_q;
						rnd_q   <= 7'd0;
						ph_q    <= 1'b0;
					end
				end
				ST_ROUND: begin
					if (!ph_q) begin
						if (rnd_q != 7'd0) begin
							work_q <= wv_next;
						end
						if (rnd_q == NUM_ROUNDS) begin
							state_q <= ST_FINAL;
						end else begin
							ph_q <= 1'b1;
						end
					end else begin
						x3_q  <= rd_a_q;
						x8_q  <= rd_b_q;
						rnd_q <= rnd_q + 7'd1;
						ph_q  <= 1'b0;
					end
				end
				ST_FINAL: begin
					rnd_q <= 7'd0;
					if (pad_q == PAD_DONE) begin
						if (out_load) begin
							out_q       <= '{digest_h0: sum.a, digest_h1: sum.b,
								digest_h2: sum.c, digest_h3: sum.d, digest_h4: sum.e};
							chain_q     <= IV;
							bitlen_q    <= 64'd0;
							pad_q       <= PAD_NONE;
							state_q     <= ST_IDLE;
						end
					end else begin
						chain_q <= sum;
						state_q <= (pad_q == PAD_NONE) ? ST_IDLE : ST_PAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`SHA1_ASSERT(a_round_bound, (state_q == ST_ROUND) |-> (rnd_q <= NUM_ROUNDS), "round index past 80")
	`SHA1_ASSERT(a_round_fill, (state_q == ST_ROUND) |-> (fill_q == 4'd0), "compression with partial block")
	`SHA1_ASSERT(a_out_source, $rose(out_valid_q) |-> $past(state_q == ST_FINAL), "digest not from final step")
	`SHA1_ASSERT_ALWAYS(a_pad_done, (pad_q == PAD_DONE) |-> (state_q == ST_ROUND || state_q == ST_FINAL), "padding done outside compression")

endmodule

### bench/sha1_digest_checker.sv
`timescale 1ns / 1ps
// Checker that predicts SHA-1 digests from accepted words and compares each digest item.
module sha1_digest_checker import sha1_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        word_valid,
	input  logic        word_stall,
	input  msg_t        word_data,
	input  logic        digest_valid,
	input  logic        digest_stall,
	input  dgst_t       digest_data,
	output int unsigned outstanding,
	output int unsigned fail_count,
	output int unsigned digests_checked
);

	logic [31:0] chain [5];
	logic [31:0] sched [16];
	logic [3:0]  fill;
	logic [63:0] total_bits;
	dgst_t       digests_due [$];

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	task automatic restart_message();
		chain[0] = IV0;
		chain[1] = IV1;
		chain[2] = IV2;
		chain[3] = IV3;
		chain[4] = IV4;
		fill = '0;
		total_bits = '0;
	endtask

	task automatic compress_block();
		logic [31:0] a, b, c, d, e, f, k, w, sum;
		int t;
		a = chain[0];
		b = chain[1];
		c = chain[2];
		d = chain[3];
		e = chain[4];
		for (t = 0; t < 80; t++) begin
			if (t < 16) begin
				w = sched[t];
			end else begin
				w = sched[(t - 3) & 15] ^ sched[(t - 8) & 15]
					^ sched[(t - 14) & 15] ^ sched[t & 15];
				w = rotl32(w, 1);
				sched[t & 15] = w;
			end
			if (t < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A82_7999;
			end else if (t < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9_EBA1;
			end else if (t < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1B_BCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62_C1D6;
			end
			sum = rotl32(a, 5) + f + e + k + w;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = sum;
		end
		chain[0] = chain[0] + a;
		chain[1] = chain[1] + b;
		chain[2] = chain[2] + c;
		chain[3] = chain[3] + d;
		chain[4] = chain[4] + e;
	endtask

	task automatic absorb_word(input logic [31:0] w);
		sched[fill] = w;
		fill = fill + 4'd1;
		if (fill == 4'd0) begin
			compress_block();
		end
	endtask

	task automatic take_word(input msg_t m);
		int unsigned n;
		logic [31:0] tail;
		if (!m.last_word) begin
			total_bits = total_bits + 64'd32;
			absorb_word(m.message_word);
		end else begin
			n = (m.byte_count > 3'd4) ? 4 : m.byte_count;
			total_bits = total_bits + 64'(8 * n);
			if (n == 4) begin
				absorb_word(m.message_word);
				absorb_word(PAD_MARK_WORD);
			end else begin
				tail = m.message_word & ~(32'hFFFF_FFFF >> (8 * n));
				absorb_word(tail | (PAD_MARK_WORD >> (8 * n)));
			end
			while (fill != 4'd14) begin
				absorb_word('0);
			end
			absorb_word(total_bits[63:32]);
			absorb_word(total_bits[31:0]);
			digests_due.push_back({chain[0], chain[1], chain[2], chain[3], chain[4]});
			restart_message();
		end
	endtask

	always @(posedge clk) begin : watch
		dgst_t want;
		int i;
		if (!arst_n) begin
			restart_message();
			digests_due.delete();
			fail_count = 0;
			digests_checked = 0;
			outstanding <= 0;
		end else begin
			if (word_valid && !word_stall) begin
				take_word(word_data);
			end
			if (digest_valid && !digest_stall) begin
				if (digests_due.size() == 0) begin
					$error("digest %h arrived with none expected", digest_data);
					fail_count++;
				end else begin
					want = digests_due.pop_front();
					digests_checked++;
					for (i = 0; i < 5; i++) begin
						if (digest_data[159 - 32 * i -: 32] !== want[159 - 32 * i -: 32]) begin
							$error("digest_h%0d: expected %h, actual %h", i,
								want[159 - 32 * i -: 32], digest_data[159 - 32 * i -: 32]);
							fail_count++;
						end
					end
				end
			end
			outstanding <= digests_due.size();
		end
	end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the SHA-1 engine: clock, reset, word stimulus, digest sink and verdict.
module tb_top;
	import sha1_pkg::*;

	localparam int unsigned WORD_GOAL    = 1400;
	localparam int unsigned CYCLE_LIMIT  = 3_000_000;
	localparam int unsigned LONG_HOLD_AT = 25;
	localparam int unsigned LONG_HOLD    = 4000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  word_valid = 1'b0;
	logic  word_stall;
	msg_t  word_data = '0;
	logic  digest_valid;
	logic  digest_stall = 1'b0;
	dgst_t digest_data;

	int unsigned outstanding;
	int unsigned fail_count;
	int unsigned digests_checked;
	int unsigned cycles = 0;
	int unsigned sink_wait = 0;
	int unsigned digests_taken = 0;
	int unsigned words_sent = 0;
	int unsigned messages_sent = 0;
	bit          burst = 1'b0;

	sha1_hash_engine_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.word_data    (word_data),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest_data  (digest_data)
	);

	sha1_digest_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.word_data       (word_data),
		.digest_valid    (digest_valid),
		.digest_stall    (digest_stall),
		.digest_data     (digest_data),
		.outstanding     (outstanding),
		.fail_count      (fail_count),
		.digests_checked (digests_checked)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// hold each digest item for a drawn number of valid cycles; one long hold fills the engine
	always @(posedge clk) begin
		if (digest_valid && !digest_stall) begin
			digests_taken++;
			if (digests_taken == LONG_HOLD_AT) begin
				sink_wait = LONG_HOLD;
			end else if ($urandom_range(0, 3) == 0) begin
				sink_wait = 0;
			end else begin
				sink_wait = $urandom_range(0, 5);
			end
		end else if (digest_valid && sink_wait > 0) begin
			sink_wait--;
		end
		digest_stall <= (sink_wait != 0);
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input msg_t m);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			word_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		word_valid <= 1'b1;
		word_data <= m;
		@(posedge clk);
		while (word_stall) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_message(input int unsigned body_words, input logic [31:0] tail,
			input logic [2:0] tail_count);
		msg_t m;
		int unsigned i;
		for (i = 0; i < body_words; i++) begin
			m.message_word = pick_word();
			m.byte_count = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
			m.last_word = 1'b0;
			send_word(m);
		end
		m.message_word = tail;
		m.byte_count = tail_count;
		m.last_word = 1'b1;
		send_word(m);
		messages_sent++;
	endtask

	initial begin : stimulus
		int unsigned body;
		logic [2:0] tail_count;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_message(0, 32'hDEAD_BEEF, 3'd0);
		send_message(0, 32'h6162_63FF, 3'd3);
		send_message(0, 32'h0000_0000, 3'd4);
		send_message(0, 32'hFFFF_FFFF, 3'd7);
		send_message(1, 32'h1234_5678, 3'd1);
		send_message(15, 32'hFFFF_FFFF, 3'd3);

		while (words_sent < WORD_GOAL) begin
			burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: body = $urandom_range(0, 20);
				6, 7:             body = 13 + $urandom_range(0, 3) + 16 * $urandom_range(0, 1);
				default:          body = $urandom_range(21, 90);
			endcase
			if ($urandom_range(0, 7) == 0) begin
				tail_count = 3'($urandom_range(5, 7));
			end else begin
				tail_count = 3'($urandom_range(0, 4));
			end
			send_message(body, pick_word(), tail_count);
			if (messages_sent % 15 == 7) begin
				word_valid <= 1'b0;
				@(posedge clk);
				while (outstanding != 0) @(posedge clk);
			end
		end

		word_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Hashed %0d messages from %0d words, %0d digests compared.",
			messages_sent, words_sent, digests_checked);
		$display("Covered empty and partial tails, two-block padding, a long output hold.");
		if (fail_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### sha1_hash_engine_core.f
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_round.sv
hdl/sha1_hash_engine_core.sv
bench/sha1_digest_checker.sv
bench/tb_top.sv
